/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands; compiled out when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication
`define ASSERT_IMPLIES(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication
`define ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPLIES(lbl, ck, rn, ante, cons)
`define ASSERT_NEXT(lbl, ck, rn, ante, cons)

`endif

`endif

/* hdl/trirast_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trirast_pkg
// Shared types, microcode word layout and constants of the rasterizer.
// ----------------------------------------------------------------------------
package trirast_pkg;

  localparam int CoordW = 11;   // vertex coordinate
  localparam int DiffW  = 12;   // coordinate differences, box bounds, scan position
  localparam int ProdW  = 24;   // one multiplier product
  localparam int AccW   = 25;   // accumulator
  localparam int EdgeW  = 24;   // edge function value
  localparam int FieldW = 21;   // weight / area result fields
  localparam int UpcW   = 4;

  // Rejection limits on edge spans and clip limits of the raster
  localparam int SpanXLimit = 1024;
  localparam int SpanYLimit = 512;
  localparam int MaxX       = 1024;
  localparam int MaxY       = 512;

  // Input op codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_NEXT = 1'b1;

  // Microcode entry points
  localparam logic [UpcW-1:0] UA_IDLE = 4'd0;
  localparam logic [UpcW-1:0] UA_LOAD = 4'd1;
  localparam logic [UpcW-1:0] UA_SCAN = 4'd14;
  localparam logic [UpcW-1:0] UA_DONE = 4'd15;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [DiffW-1:0]  diff_t;
  typedef logic signed [EdgeW-1:0]  edge_t;

  // Multiplier operand pair
  typedef enum logic [1:0] {
    MUL_ORI_A,   // (x1-x0)*(y2-y0)
    MUL_ORI_B,   // (y1-y0)*(x2-x0)
    MUL_EDGE_Y,  // step_y[e]*(top-ya)
    MUL_EDGE_X   // step_x[e]*(left-xa)
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_KEEP,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB
  } acc_op_t;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_WIND,    // winding fix, area capture
    ACT_BOX,     // bounding box, steps, top-left bias
    ACT_WROW,    // write one edge row start
    ACT_LAST,    // write last edge row and arm the scan
    ACT_SCAN,    // test one box pixel
    ACT_DONE     // send a done beat
  } act_t;

  typedef enum logic [2:0] {
    JMP_NEXT,
    JMP_IDLE,
    JMP_DISPATCH,
    JMP_REJECT,
    JMP_SCAN
  } jmp_t;

  typedef struct packed {
    mul_sel_t   mul_sel;
    logic [1:0] mul_edg;
    acc_op_t    acc_op;
    act_t       act;
    logic [1:0] wr_edg;
    jmp_t       jmp;
  } uword_t;

  // Datapath status back to the sequencer
  typedef struct packed {
    logic hold;      // step wants to send a beat but output is full
    logic reject;    // triangle spans too far or has zero area
    logic scan_fin;  // scan step sends a beat this cycle
  } dp_stat_t;

endpackage

/* hdl/trirast_useq.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// trirast_useq
// Microcode sequencer: step counter, control ROM and jump logic.
// ----------------------------------------------------------------------------
module trirast_useq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  logic                in_op,
  input  trirast_pkg::dp_stat_t stat,
  output trirast_pkg::uword_t   ctl,
  output logic                idle
);
  import trirast_pkg::*;

  logic [UpcW-1:0] upc_r, upc_nxt;

  // Control store
  function automatic uword_t urom(input logic [UpcW-1:0] a);
    uword_t w;
    w = '{mul_sel: MUL_ORI_A, mul_edg: 2'd0, acc_op: ACC_KEEP, act: ACT_NONE,
          wr_edg: 2'd0, jmp: JMP_NEXT};
    unique case (a)
      UA_IDLE:          w.jmp = JMP_DISPATCH;
      // doubled signed area
      UA_LOAD:          w.mul_sel = MUL_ORI_A;
      UA_LOAD + 4'd1:   begin w.mul_sel = MUL_ORI_B; w.acc_op = ACC_LOAD; end
      UA_LOAD + 4'd2:   w.acc_op = ACC_SUB;
      UA_LOAD + 4'd3:   begin w.act = ACT_WIND; w.jmp = JMP_REJECT; end
      UA_LOAD + 4'd4:   w.act = ACT_BOX;
      // edge values at the box corner, two products each
      UA_LOAD + 4'd5:   begin w.mul_sel = MUL_EDGE_Y; w.mul_edg = 2'd0; end
      UA_LOAD + 4'd6:   begin
        w.mul_sel = MUL_EDGE_X; w.mul_edg = 2'd0; w.acc_op = ACC_LOAD;
      end
      UA_LOAD + 4'd7:   begin
        w.mul_sel = MUL_EDGE_Y; w.mul_edg = 2'd1; w.acc_op = ACC_ADD;
      end
      UA_LOAD + 4'd8:   begin
        w.mul_sel = MUL_EDGE_X; w.mul_edg = 2'd1; w.acc_op = ACC_LOAD;
        w.act = ACT_WROW; w.wr_edg = 2'd0;
      end
      UA_LOAD + 4'd9:   begin
        w.mul_sel = MUL_EDGE_Y; w.mul_edg = 2'd2; w.acc_op = ACC_ADD;
      end
      UA_LOAD + 4'd10:  begin
        w.mul_sel = MUL_EDGE_X; w.mul_edg = 2'd2; w.acc_op = ACC_LOAD;
        w.act = ACT_WROW; w.wr_edg = 2'd1;
      end
      UA_LOAD + 4'd11:  w.acc_op = ACC_ADD;
      UA_LOAD + 4'd12:  begin w.act = ACT_LAST; w.wr_edg = 2'd2; w.jmp = JMP_IDLE; end
      UA_SCAN:          begin w.act = ACT_SCAN; w.jmp = JMP_SCAN; end
      UA_DONE:          begin w.act = ACT_DONE; w.jmp = JMP_IDLE; end
      default:          w.jmp = JMP_IDLE;
    endcase
    return w;
  endfunction

  assign ctl  = urom(upc_r);
  assign idle = (upc_r == UA_IDLE);

  // Next step
  always_comb begin
    upc_nxt = upc_r;
    if (!stat.hold) begin
      unique case (ctl.jmp)
        JMP_NEXT:     upc_nxt = upc_r + 1'b1;
        JMP_IDLE:     upc_nxt = UA_IDLE;
        JMP_DISPATCH: if (in_fire) upc_nxt = (in_op == OP_NEXT) ? UA_SCAN : UA_LOAD;
        JMP_REJECT:   upc_nxt = stat.reject ? UA_DONE : upc_r + 1'b1;
        JMP_SCAN:     upc_nxt = stat.scan_fin ? UA_IDLE : upc_r;
        default:      upc_nxt = UA_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= UA_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

  `ASSERT_NEXT(a_hold_upc, clk, rst_n, stat.hold, upc_r == $past(upc_r))
  `ASSERT_NEXT(a_load_entry, clk, rst_n, in_fire && in_op == OP_LOAD, upc_r == UA_LOAD)
  `ASSERT_NEXT(a_reject_done, clk, rst_n, ctl.jmp == JMP_REJECT && stat.reject, upc_r == UA_DONE)

endmodule

/* hdl/trirast_dpath.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// trirast_dpath
// Datapath: vertex and edge registers, shared multiplier with accumulator,
// box scan logic, config registers and the output beat register.
// ----------------------------------------------------------------------------
module trirast_dpath (
  input  logic                  clk,
  input  logic                  rst_n,
  input  trirast_pkg::uword_t   ctl,
  input  logic                  load,
  input  trirast_pkg::coord_t   vx0,
  input  trirast_pkg::coord_t   vy0,
  input  trirast_pkg::coord_t   vx1,
  input  trirast_pkg::coord_t   vy1,
  input  trirast_pkg::coord_t   vx2,
  input  trirast_pkg::coord_t   vy2,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_addr,
  input  logic [10:0]           cfg_wdata,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [9:0]            pix_x,
  output logic [8:0]            pix_y,
  output logic [20:0]           weight0,
  output logic [20:0]           weight1,
  output logic [20:0]           weight2,
  output logic [20:0]           tri_area,
  output logic                  done_res,
  output trirast_pkg::dp_stat_t stat
);
  import trirast_pkg::*;

  localparam logic [1:0]  CFG_AREA_LEFT   = 2'd0;
  localparam logic [1:0]  CFG_AREA_TOP    = 2'd1;
  localparam logic [1:0]  CFG_AREA_RIGHT  = 2'd2;
  localparam logic [1:0]  CFG_AREA_BOTTOM = 2'd3;
  localparam logic [12:0] SpanX = 13'(SpanXLimit);
  localparam logic [12:0] SpanY = 13'(SpanYLimit);

  // Config registers
  logic [9:0]  area_left_r;
  logic [8:0]  area_top_r;
  logic [10:0] area_right_r;
  logic [9:0]  area_bottom_r;

  // Triangle state
  coord_t      vx_r [3];
  coord_t      vy_r [3];
  diff_t       stepx_r [3];
  diff_t       stepy_r [3];
  logic [2:0]  bias_r;
  edge_t       row_r [3];
  edge_t       col_r [3];
  diff_t       box_l_r, box_t_r, box_rt_r, box_b_r;
  diff_t       scan_x_r, scan_y_r;
  logic [23:0] area_r;
  logic        active_r;

  // Multiplier and accumulator
  logic signed [ProdW-1:0] prod_r;
  logic signed [AccW-1:0]  acc_r;
  diff_t                   opa, opb;

  // Output beat
  logic        out_valid_r, out_done_r;
  logic [9:0]  out_px_r;
  logic [8:0]  out_py_r;
  logic [20:0] out_w0_r, out_w1_r, out_w2_r, out_area_r;

  function automatic logic [1:0] idx_a(input logic [1:0] i);
    unique case (i)
      2'd0:    return 2'd1;
      2'd1:    return 2'd2;
      default: return 2'd0;
    endcase
  endfunction

  function automatic logic [1:0] idx_b(input logic [1:0] i);
    unique case (i)
      2'd0:    return 2'd2;
      2'd1:    return 2'd0;
      default: return 2'd1;
    endcase
  endfunction

  function automatic logic [12:0] abs_d(input diff_t d);
    return d[DiffW-1] ? 13'(-d) : 13'(d);
  endfunction

  function automatic coord_t min3(input coord_t a, input coord_t b, input coord_t c);
    coord_t m;
    m = (a < b) ? a : b;
    return (c < m) ? c : m;
  endfunction

  function automatic coord_t max3(input coord_t a, input coord_t b, input coord_t c);
    coord_t m;
    m = (a > b) ? a : b;
    return (c > m) ? c : m;
  endfunction

  function automatic logic [20:0] sat21(input logic [23:0] v);
    return (|v[23:21]) ? '1 : v[20:0];
  endfunction

  // Vertex differences
  diff_t dx10, dy10, dx20, dy20, dx21, dy21;
  assign dx10 = diff_t'(vx_r[1]) - diff_t'(vx_r[0]);
  assign dy10 = diff_t'(vy_r[1]) - diff_t'(vy_r[0]);
  assign dx20 = diff_t'(vx_r[2]) - diff_t'(vx_r[0]);
  assign dy20 = diff_t'(vy_r[2]) - diff_t'(vy_r[0]);
  assign dx21 = diff_t'(vx_r[2]) - diff_t'(vx_r[1]);
  assign dy21 = diff_t'(vy_r[2]) - diff_t'(vy_r[1]);

  // Rejection: any edge too long (zero area is caught from the accumulator)
  logic span_bad;
  assign span_bad = (abs_d(dx10) >= SpanX) || (abs_d(dx21) >= SpanX) ||
                    (abs_d(dx20) >= SpanX) || (abs_d(dy10) >= SpanY) ||
                    (abs_d(dy21) >= SpanY) || (abs_d(dy20) >= SpanY);

  // Operand select
  logic [1:0] ma;
  assign ma = idx_a(ctl.mul_edg);

  always_comb begin
    opa = '0;
    opb = '0;
    unique case (ctl.mul_sel)
      MUL_ORI_A:  begin opa = dx10; opb = dy20; end
      MUL_ORI_B:  begin opa = dy10; opb = dx20; end
      MUL_EDGE_Y: begin opa = stepy_r[ctl.mul_edg]; opb = box_t_r - diff_t'(vy_r[ma]); end
      MUL_EDGE_X: begin opa = stepx_r[ctl.mul_edg]; opb = box_l_r - diff_t'(vx_r[ma]); end
      default:    begin opa = '0; opb = '0; end
    endcase
  end

  // Bounding box clipped to the drawing area
  coord_t      mnx, mxx, mny, mxy;
  logic [10:0] rlim;
  logic [9:0]  blim;
  diff_t       left_c, top_c, right_c, bottom_c;
  assign mnx  = min3(vx_r[0], vx_r[1], vx_r[2]);
  assign mxx  = max3(vx_r[0], vx_r[1], vx_r[2]);
  assign mny  = min3(vy_r[0], vy_r[1], vy_r[2]);
  assign mxy  = max3(vy_r[0], vy_r[1], vy_r[2]);
  assign rlim = (area_right_r < 11'(MaxX)) ? area_right_r : 11'(MaxX);
  assign blim = (area_bottom_r < 10'(MaxY)) ? area_bottom_r : 10'(MaxY);
  assign left_c   = (diff_t'(mnx) > $signed({2'b00, area_left_r})) ?
                    diff_t'(mnx) : $signed({2'b00, area_left_r});
  assign top_c    = (diff_t'(mny) > $signed({3'b000, area_top_r})) ?
                    diff_t'(mny) : $signed({3'b000, area_top_r});
  assign right_c  = (diff_t'(mxx) < $signed({1'b0, rlim})) ?
                    diff_t'(mxx) : $signed({1'b0, rlim});
  assign bottom_c = (diff_t'(mxy) < $signed({2'b00, blim})) ?
                    diff_t'(mxy) : $signed({2'b00, blim});

  // Edge steps and top-left bias
  diff_t      stx_c [3];
  diff_t      sty_c [3];
  logic [2:0] bias_c;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      stx_c[i]  = diff_t'(vy_r[idx_a(2'(i))]) - diff_t'(vy_r[idx_b(2'(i))]);
      sty_c[i]  = diff_t'(vx_r[idx_b(2'(i))]) - diff_t'(vx_r[idx_a(2'(i))]);
      bias_c[i] = stx_c[i][DiffW-1] || (stx_c[i] == '0 && sty_c[i][DiffW-1]);
    end
  end

  // Biased edge value from the accumulator
  edge_t wr_val;
  assign wr_val = edge_t'(acc_r[EdgeW-1:0] - EdgeW'(bias_r[ctl.wr_edg]));

  // Scan
  logic  sy_end, sx_end, hit, scan_end, scan_emit, emit_want, emit_done, hold, go;
  logic  is_scan, is_done_act, scan_step;
  edge_t row_nxt [3];
  assign is_scan     = (ctl.act == ACT_SCAN);
  assign is_done_act = (ctl.act == ACT_DONE);
  assign sy_end      = (scan_y_r >= box_b_r);
  assign sx_end      = (scan_x_r >= box_rt_r);
  assign hit         = !col_r[0][EdgeW-1] && !col_r[1][EdgeW-1] && !col_r[2][EdgeW-1] &&
                       ((col_r[0] | col_r[1] | col_r[2]) != '0);
  assign scan_end    = !active_r || sy_end;
  assign scan_emit   = scan_end || (!sx_end && hit);
  assign emit_want   = (is_scan && scan_emit) || is_done_act;
  assign emit_done   = is_done_act || (is_scan && scan_end);
  assign hold        = emit_want && out_valid_r && !out_ready;
  assign go          = !hold;
  assign scan_step   = go && is_scan && active_r && !sy_end;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      row_nxt[i] = row_r[i] + edge_t'(stepy_r[i]);
    end
  end

  // Unbiased weights
  logic [23:0] w0s, w1s, w2s;
  assign w0s = col_r[0][EdgeW-1:0] + 24'(bias_r[0]);
  assign w1s = col_r[1][EdgeW-1:0] + 24'(bias_r[1]);
  assign w2s = col_r[2][EdgeW-1:0] + 24'(bias_r[2]);

  assign stat.hold     = hold;
  assign stat.reject   = span_bad || (acc_r == '0);
  assign stat.scan_fin = scan_emit;

  // Control state and config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r      <= 1'b0;
      out_valid_r   <= 1'b0;
      area_left_r   <= '0;
      area_top_r    <= '0;
      area_right_r  <= 11'(MaxX);
      area_bottom_r <= 10'(MaxY);
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_AREA_LEFT:   area_left_r   <= cfg_wdata[9:0];
          CFG_AREA_TOP:    area_top_r    <= cfg_wdata[8:0];
          CFG_AREA_RIGHT:  area_right_r  <= cfg_wdata;
          CFG_AREA_BOTTOM: area_bottom_r <= cfg_wdata[9:0];
          default:         area_left_r   <= area_left_r;
        endcase
      end
      if (load) begin
        active_r <= 1'b0;
      end else if (go && ctl.act == ACT_LAST) begin
        active_r <= 1'b1;
      end else if (go && is_scan && active_r && sy_end) begin
        active_r <= 1'b0;
      end
      if (go && emit_want) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (load) begin
      vx_r[0] <= vx0; vy_r[0] <= vy0;
      vx_r[1] <= vx1; vy_r[1] <= vy1;
      vx_r[2] <= vx2; vy_r[2] <= vy2;
    end

    prod_r <= opa * opb;
    case (ctl.acc_op)
      ACC_LOAD: acc_r <= AccW'(prod_r);
      ACC_ADD:  acc_r <= acc_r + AccW'(prod_r);
      ACC_SUB:  acc_r <= acc_r - AccW'(prod_r);
      default:  acc_r <= acc_r;
    endcase

    // Clockwise input: swap vertices 1 and 2, area becomes positive
    if (ctl.act == ACT_WIND && !stat.reject) begin
      if (acc_r[AccW-1]) begin
        vx_r[1] <= vx_r[2]; vy_r[1] <= vy_r[2];
        vx_r[2] <= vx_r[1]; vy_r[2] <= vy_r[1];
        area_r  <= 24'(-acc_r);
      end else begin
        area_r  <= acc_r[23:0];
      end
    end

    if (ctl.act == ACT_BOX) begin
      box_l_r  <= left_c;
      box_t_r  <= top_c;
      box_rt_r <= right_c;
      box_b_r  <= bottom_c;
      bias_r   <= bias_c;
      for (int i = 0; i < 3; i++) begin
        stepx_r[i] <= stx_c[i];
        stepy_r[i] <= sty_c[i];
      end
    end

    if (ctl.act == ACT_WROW || ctl.act == ACT_LAST) begin
      row_r[ctl.wr_edg] <= wr_val;
      col_r[ctl.wr_edg] <= wr_val;
    end
    if (ctl.act == ACT_LAST) begin
      scan_x_r <= box_l_r;
      scan_y_r <= box_t_r;
    end

    // One box pixel, or a row wrap, per cycle unless a full output register holds the scan
    if (scan_step) begin
      if (sx_end) begin
        for (int i = 0; i < 3; i++) begin
          row_r[i] <= row_nxt[i];
          col_r[i] <= row_nxt[i];
        end
        scan_x_r <= box_l_r;
        scan_y_r <= scan_y_r + 1'b1;
      end else begin
        for (int i = 0; i < 3; i++) begin
          col_r[i] <= col_r[i] + edge_t'(stepx_r[i]);
        end
        scan_x_r <= scan_x_r + 1'b1;
      end
    end

    if (go && emit_want) begin
      out_done_r <= emit_done;
      if (emit_done) begin
        out_px_r   <= '0;
        out_py_r   <= '0;
        out_w0_r   <= '0;
        out_w1_r   <= '0;
        out_w2_r   <= '0;
        out_area_r <= '0;
      end else begin
        out_px_r   <= scan_x_r[9:0];
        out_py_r   <= scan_y_r[8:0];
        out_w0_r   <= sat21(w0s);
        out_w1_r   <= sat21(w1s);
        out_w2_r   <= sat21(w2s);
        out_area_r <= sat21(area_r);
      end
    end
  end

  assign out_valid = out_valid_r;
  assign pix_x     = out_px_r;
  assign pix_y     = out_py_r;
  assign weight0   = out_w0_r;
  assign weight1   = out_w1_r;
  assign weight2   = out_w2_r;
  assign tri_area  = out_area_r;
  assign done_res  = out_done_r;

  `ASSERT_IMPLIES(a_done_blank, clk, rst_n, out_valid_r && out_done_r, out_w0_r == '0 && out_area_r == '0 && out_px_r == '0)
  `ASSERT_IMPLIES(a_reject_idle, clk, rst_n, ctl.act == ACT_WIND && stat.reject, !active_r)
  `ASSERT_NEXT(a_hit_beat, clk, rst_n, scan_step && !sx_end && hit, out_valid_r && !out_done_r)

endmodule

/* hdl/triangle_edge_rasterizer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_edge_rasterizer
// Half-space triangle rasterizer with top-left fill rule, run by a microcode
// sequencer over one shared multiplier datapath.
// ----------------------------------------------------------------------------
//  channel   dir  width  contents
//  in_       in   72+1   tdata: vx0 vy0 vx1 vy1 vx2 vy2; tuser: op
//  out_      out  104+1  tdata: pix_x pix_y weight0..2 tri_area; tuser: done_res
//  cfg_      in   2/11   register index / write data, no read-back
//
//  Load: a run of microcode steps in which the shared 12x12 multiplier does
//  eight products; a rejected load jumps to the done step to send its beat.
//  Next: the scan tests each box pixel in turn, wrapping at each row end.
//  Input is taken only in the idle step; a finished beat may wait in the
//  output register while the next item is taken, and a step that must send a
//  beat stalls while that register is full. Reset is synchronous, active low.
// ----------------------------------------------------------------------------
module triangle_edge_rasterizer (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_addr,
  input  logic [10:0]  cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [71:0]  in_tdata,   // vx0, vy0, vx1, vy1, vx2, vy2 (11b each), zero pad
  input  logic         in_tuser,   // op
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata,  // pix_x, pix_y, weight0, weight1, weight2, tri_area, pad
  output logic         out_tuser   // done_res
);
  import trirast_pkg::*;

  uword_t      ctl;
  dp_stat_t    stat;
  logic        idle, in_fire, load;
  logic [9:0]  pix_x;
  logic [8:0]  pix_y;
  logic [20:0] weight0, weight1, weight2, tri_area;

  assign in_tready = idle;
  assign in_fire   = in_tvalid && in_tready;
  assign load      = in_fire && (in_tuser == OP_LOAD);

  trirast_useq u_useq (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_op   (in_tuser),
    .stat    (stat),
    .ctl     (ctl),
    .idle    (idle)
  );

  trirast_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .load      (load),
    .vx0       (in_tdata[10:0]),
    .vy0       (in_tdata[21:11]),
    .vx1       (in_tdata[32:22]),
    .vy1       (in_tdata[43:33]),
    .vx2       (in_tdata[54:44]),
    .vy2       (in_tdata[65:55]),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .pix_x     (pix_x),
    .pix_y     (pix_y),
    .weight0   (weight0),
    .weight1   (weight1),
    .weight2   (weight2),
    .tri_area  (tri_area),
    .done_res  (out_tuser),
    .stat      (stat)
  );

  // Result beat packing, first field lowest
  assign out_tdata = {1'b0, tri_area, weight2, weight1, weight0, pix_y, pix_x};

endmodule
